FILE: hdl/hip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hip_pkg
// Types, character codes and status codes shared by the hex integer parser.
// ----------------------------------------------------------------------------
package hip_pkg;

	localparam int DIGIT_BITS = 5;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_WHITE  = 4'd1,
		PH_BSL    = 4'd2,
		PH_HASH   = 4'd3,
		PH_AMP    = 4'd4,
		PH_AMPH   = 4'd5,
		PH_NEED   = 4'd6,
		PH_ZERO   = 4'd7,
		PH_DIGITS = 4'd8,
		PH_DONE   = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		RC_PEND = 2'd0,
		RC_OK   = 2'd1,
		RC_FAIL = 2'd2,
		RC_OVF  = 2'd3
	} outcome_t;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FAIL = 2'd1;
	localparam logic [1:0] STATUS_OVF  = 2'd2;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	localparam logic [4:0] HEX_NONE = 5'd16;

	typedef struct packed {
		phase_t                  phase;
		logic [63:0]             acc;
		logic [DIGIT_BITS-1:0]   digits;
	} core_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] value;
		logic [15:0] read_count;
	} result_t;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] d;
		d = HEX_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = 5'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = 5'(c - 8'h41 + 8'd10);
		end
		return d;
	endfunction

	function automatic logic is_x(input logic [7:0] c);
		return (c == CH_LOW_X) || (c == CH_UP_X);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/hip_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hip_in_if
// Character channel: one byte per request with first and last marks.
// ----------------------------------------------------------------------------
interface hip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       first;
	logic       last;

	modport source (output valid, ch, first, last, input ready);
	modport sink (input valid, ch, first, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/hip_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hip_out_if
// Result channel: status, value and character count per request.
// ----------------------------------------------------------------------------
interface hip_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] value;
	logic [15:0] read_count;

	modport source (output valid, status, value, read_count, input ready);
	modport sink (input valid, status, value, read_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/hip_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hip_step
// Next-state and result logic for one character of the parse.
// ----------------------------------------------------------------------------
module hip_step #(
	parameter int COUNT_BITS = 16,
	parameter int MAX_DIGITS = 16
) (
	input  wire hip_pkg::core_t  cur,
	input  wire [COUNT_BITS-1:0] cur_count,
	input  wire [7:0]            ch,
	input  wire                  first,
	input  wire                  last,
	output hip_pkg::core_t       nxt,
	output logic [COUNT_BITS-1:0] nxt_count,
	output logic                 emit,
	output hip_pkg::result_t     res
);

	always_comb begin
		hip_pkg::core_t    st;
		logic [COUNT_BITS-1:0] cnt;
		hip_pkg::outcome_t r;
		logic              do_bump;
		logic              do_take;
		logic              need;
		logic              zero_mark;
		logic [4:0]        d;
		logic [31:0]       cnt_w;

		st        = cur;
		cnt       = cur_count;
		r         = hip_pkg::RC_PEND;
		do_bump   = 1'b0;
		do_take   = 1'b0;
		need      = 1'b0;
		zero_mark = 1'b0;
		d         = hip_pkg::hex_value(ch);
		emit      = 1'b0;

		if (first) begin
			st.phase  = hip_pkg::PH_WHITE;
			st.acc    = 64'd0;
			st.digits = '0;
			cnt       = '0;
		end

		if (st.phase != hip_pkg::PH_IDLE && st.phase != hip_pkg::PH_DONE) begin
			case (st.phase)
				hip_pkg::PH_WHITE: begin
					if (ch == hip_pkg::CH_SPACE || ch == hip_pkg::CH_TAB ||
					    ch == hip_pkg::CH_CR || ch == hip_pkg::CH_LF) begin
						do_bump = 1'b1;
					end else if (ch == hip_pkg::CH_DOLLAR || hip_pkg::is_x(ch)) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_NEED;
					end else if (ch == hip_pkg::CH_BSL) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_BSL;
					end else if (ch == hip_pkg::CH_HASH) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_HASH;
					end else if (ch == hip_pkg::CH_AMP) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_AMP;
					end else if (ch == hip_pkg::CH_ZERO) begin
						do_take   = 1'b1;
						zero_mark = 1'b1;
					end else begin
						need = 1'b1;
					end
				end
				hip_pkg::PH_BSL: begin
					if (ch == hip_pkg::CH_LOW_U) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_NEED;
					end else begin
						r = hip_pkg::RC_FAIL;
					end
				end
				hip_pkg::PH_HASH: begin
					if (ch == hip_pkg::CH_DOLLAR || hip_pkg::is_x(ch)) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_NEED;
					end else begin
						need = 1'b1;
					end
				end
				hip_pkg::PH_AMP: begin
					if (ch == hip_pkg::CH_HASH) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_AMPH;
					end else begin
						r = hip_pkg::RC_FAIL;
					end
				end
				hip_pkg::PH_AMPH: begin
					if (hip_pkg::is_x(ch)) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_NEED;
					end else begin
						r = hip_pkg::RC_FAIL;
					end
				end
				hip_pkg::PH_NEED: begin
					need = 1'b1;
				end
				hip_pkg::PH_ZERO: begin
					if (hip_pkg::is_x(ch)) begin
						do_bump  = 1'b1;
						st.phase = hip_pkg::PH_NEED;
					end else if (d == hip_pkg::HEX_NONE) begin
						r = hip_pkg::RC_OK;
					end else begin
						do_take = 1'b1;
					end
				end
				default: begin
					if (d == hip_pkg::HEX_NONE) begin
						r = hip_pkg::RC_OK;
					end else begin
						do_take = 1'b1;
					end
				end
			endcase

			if (need) begin
				if (d == hip_pkg::HEX_NONE) begin
					r = hip_pkg::RC_FAIL;
				end else begin
					do_take = 1'b1;
				end
			end

			if (do_take) begin
				if (st.digits != '0 || d != 5'd0) begin
					if (st.digits >= hip_pkg::DIGIT_BITS'(MAX_DIGITS)) begin
						r = hip_pkg::RC_OVF;
					end else begin
						st.acc    = {st.acc[59:0], d[3:0]};
						st.digits = st.digits + 1'b1;
					end
				end
				if (r != hip_pkg::RC_OVF) begin
					do_bump  = 1'b1;
					st.phase = zero_mark ? hip_pkg::PH_ZERO : hip_pkg::PH_DIGITS;
				end
			end

			if (do_bump && cnt != {COUNT_BITS{1'b1}}) begin
				cnt = cnt + 1'b1;
			end

			if (r == hip_pkg::RC_PEND && last) begin
				r = (st.phase == hip_pkg::PH_DIGITS || st.phase == hip_pkg::PH_ZERO) ?
				    hip_pkg::RC_OK : hip_pkg::RC_FAIL;
			end

			if (r != hip_pkg::RC_PEND) begin
				emit     = 1'b1;
				st.phase = hip_pkg::PH_DONE;
			end
		end

		cnt_w = 32'(cnt);
		nxt       = st;
		nxt_count = cnt;
		if (r == hip_pkg::RC_OK) begin
			res.status     = hip_pkg::STATUS_OK;
			res.value      = st.acc;
			res.read_count = (cnt_w > 32'h0000_FFFF) ? 16'hFFFF : cnt_w[15:0];
		end else begin
			res.status     = (r == hip_pkg::RC_OVF) ? hip_pkg::STATUS_OVF : hip_pkg::STATUS_FAIL;
			res.value      = 64'd0;
			res.read_count = 16'd0;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/hex_integer_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_integer_parser
// Streaming parser of ASCII hex strings into 64-bit values.
// ----------------------------------------------------------------------------
// Usage
//   chars   : one character per request, with first and last marks. A
//             request with first set starts a new string and drops any
//             unfinished one. Characters outside a string are ignored.
//   results : one request per finished string: status (0 ok, 1 no digit or bad
//             prefix, 2 overflow), value and characters consumed.
//   Path    : an accepted character is registered in the input register and
//             evaluated there; its result, if any, goes to the result register.
//   Rate    : one character per cycle while no result waits; the work per
//             character is one shift-or of the 64-bit accumulator and a count
//             increment between the input register and the result register.
//   Reset   : arst_n clears the parse state to idle and empties both
//             registers; the first string may start at the next edge.
//   Stall   : while a result waits on results.ready the held character
//             and the parse state stand still and chars.ready drops once
//             the input register is also full.
// ----------------------------------------------------------------------------
module hex_integer_parser #(
	parameter int COUNT_BITS = 16,
	parameter int MAX_DIGITS = 16
) (
	input  wire       clk,
	input  wire       arst_n,
	hip_in_if.sink    chars,
	hip_out_if.source results
);

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  first_s1;
	logic                  last_s1;

	hip_pkg::core_t        core_q;
	logic [COUNT_BITS-1:0] count_q;

	logic                  out_valid_q;
	hip_pkg::result_t      res_q;

	hip_pkg::core_t        core_d;
	logic [COUNT_BITS-1:0] count_d;
	logic                  emit;
	hip_pkg::result_t      res_d;
	logic                  advance;

	assign advance     = !out_valid_q || results.ready;
	assign chars.ready = !valid_s1 || advance;

	hip_step #(
		.COUNT_BITS(COUNT_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_step (
		.cur      (core_q),
		.cur_count(count_q),
		.ch       (ch_s1),
		.first    (first_s1),
		.last     (last_s1),
		.nxt      (core_d),
		.nxt_count(count_d),
		.emit     (emit),
		.res      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1    <= chars.ch;
			first_s1 <= chars.first;
			last_s1  <= chars.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q.phase  <= hip_pkg::PH_IDLE;
			core_q.acc    <= 64'd0;
			core_q.digits <= '0;
			count_q       <= '0;
		end else if (valid_s1 && advance) begin
			core_q  <= core_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s1 && advance && emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && emit) begin
			res_q <= res_d;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.status     = res_q.status;
	assign results.value      = res_q.value;
	assign results.read_count = res_q.read_count;

`ifndef SYNTHESIS
	a_fail_clears_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != hip_pkg::STATUS_OK) |->
		(res_q.value == 64'd0 && res_q.read_count == 16'd0))
		else $error("failed result carries a non-zero payload");

	a_emit_ends_string: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && emit) |=> (core_q.phase == hip_pkg::PH_DONE))
		else $error("string not closed after its result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> (valid_s1 && out_valid_q && !results.ready))
		else $error("input stalled without a full pipeline");

	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		core_q.digits <= hip_pkg::DIGIT_BITS'(MAX_DIGITS))
		else $error("digit count beyond limit");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_hex_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_integer_parser
// Self-checking bench for the streaming hex string parser. A queue of
// character requests, filled with directed strings and a random mix of
// well-formed, broken and stray characters, feeds a clocked driver with
// random gaps. A clocked monitor with random stalls compares each result
// field by field against the parse predicted when the character that decided
// it was accepted.
// ----------------------------------------------------------------------------
module tb_hex_integer_parser;

	typedef struct {
		logic [7:0] ch;
		bit         first;
		bit         last;
		bit         drain;
		bit         burst;
	} char_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hip_in_if  chars_if ();
	hip_out_if results_if ();

	hex_integer_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	always #10 clk = ~clk;

	char_req_t          pending [$];
	hip_pkg::result_t   expected [$];
	logic [7:0]         line [$];

	// predicted parse state
	hip_pkg::phase_t    p_phase;
	logic [63:0]        p_acc;
	int unsigned        p_used;
	int unsigned        p_ndig;

	int unsigned n_total;
	int unsigned n_accepted;
	int unsigned n_results;
	int unsigned n_ok;
	int unsigned n_fail;
	int unsigned n_ovf;
	int unsigned errors;
	int unsigned counted;

	int unsigned        gap_left;
	int unsigned        stall_left;
	bit                 in_calm;
	bit                 out_calm;
	bit                 hold;
	bit                 produced;
	char_req_t          req;
	hip_pkg::result_t   res;
	hip_pkg::result_t   want;

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
		return hip_pkg::HEX_NONE;
	endfunction

	function automatic bit x_char(input logic [7:0] c);
		return c == hip_pkg::CH_LOW_X || c == hip_pkg::CH_UP_X;
	endfunction

	function automatic void bump();
		if (p_used < 32'd65535) p_used++;
	endfunction

	function automatic hip_pkg::outcome_t take_digit(input logic [3:0] d);
		if (p_ndig != 0 || d != 4'd0) begin
			if (p_ndig >= 16) return hip_pkg::RC_OVF;
			p_acc = {p_acc[59:0], d};
			p_ndig++;
		end
		bump();
		p_phase = hip_pkg::PH_DIGITS;
		return hip_pkg::RC_PEND;
	endfunction

	function automatic hip_pkg::outcome_t need_digit(input logic [7:0] c);
		logic [4:0] d;
		d = hex_nibble(c);
		if (d == hip_pkg::HEX_NONE) return hip_pkg::RC_FAIL;
		return take_digit(d[3:0]);
	endfunction

	function automatic hip_pkg::outcome_t more_digits(input logic [7:0] c);
		logic [4:0] d;
		d = hex_nibble(c);
		if (d == hip_pkg::HEX_NONE) return hip_pkg::RC_OK;
		return take_digit(d[3:0]);
	endfunction

	function automatic bit parse_char(input logic [7:0] c, input bit first, input bit last,
			output hip_pkg::result_t r);
		hip_pkg::outcome_t oc;
		oc = hip_pkg::RC_PEND;
		r = '0;
		if (first) begin
			p_phase = hip_pkg::PH_WHITE;
			p_acc = '0;
			p_used = 0;
			p_ndig = 0;
		end
		if (p_phase == hip_pkg::PH_IDLE || p_phase == hip_pkg::PH_DONE) return 1'b0;
		case (p_phase)
			hip_pkg::PH_WHITE: begin
				if (c == hip_pkg::CH_SPACE || c == hip_pkg::CH_TAB ||
						c == hip_pkg::CH_CR || c == hip_pkg::CH_LF) begin
					bump();
				end else if (c == hip_pkg::CH_DOLLAR || x_char(c)) begin
					bump();
					p_phase = hip_pkg::PH_NEED;
				end else if (c == hip_pkg::CH_BSL) begin
					bump();
					p_phase = hip_pkg::PH_BSL;
				end else if (c == hip_pkg::CH_HASH) begin
					bump();
					p_phase = hip_pkg::PH_HASH;
				end else if (c == hip_pkg::CH_AMP) begin
					bump();
					p_phase = hip_pkg::PH_AMP;
				end else if (c == hip_pkg::CH_ZERO) begin
					oc = take_digit(4'd0);
					p_phase = hip_pkg::PH_ZERO;
				end else begin
					oc = need_digit(c);
				end
			end
			hip_pkg::PH_BSL: begin
				if (c == hip_pkg::CH_LOW_U) begin
					bump();
					p_phase = hip_pkg::PH_NEED;
				end else begin
					oc = hip_pkg::RC_FAIL;
				end
			end
			hip_pkg::PH_HASH: begin
				if (c == hip_pkg::CH_DOLLAR || x_char(c)) begin
					bump();
					p_phase = hip_pkg::PH_NEED;
				end else begin
					oc = need_digit(c);
				end
			end
			hip_pkg::PH_AMP: begin
				if (c == hip_pkg::CH_HASH) begin
					bump();
					p_phase = hip_pkg::PH_AMPH;
				end else begin
					oc = hip_pkg::RC_FAIL;
				end
			end
			hip_pkg::PH_AMPH: begin
				if (x_char(c)) begin
					bump();
					p_phase = hip_pkg::PH_NEED;
				end else begin
					oc = hip_pkg::RC_FAIL;
				end
			end
			hip_pkg::PH_NEED: oc = need_digit(c);
			hip_pkg::PH_ZERO: begin
				if (x_char(c)) begin
					bump();
					p_phase = hip_pkg::PH_NEED;
				end else begin
					oc = more_digits(c);
				end
			end
			default: oc = more_digits(c);
		endcase
		if (oc == hip_pkg::RC_PEND) begin
			if (!last) return 1'b0;
			oc = (p_phase == hip_pkg::PH_DIGITS || p_phase == hip_pkg::PH_ZERO) ?
				hip_pkg::RC_OK : hip_pkg::RC_FAIL;
		end
		p_phase = hip_pkg::PH_DONE;
		if (oc == hip_pkg::RC_OK) begin
			r.status = hip_pkg::STATUS_OK;
			r.value = p_acc;
			r.read_count = (p_used > 32'd65535) ? 16'hFFFF : p_used[15:0];
		end else begin
			r.status = (oc == hip_pkg::RC_OVF) ? hip_pkg::STATUS_OVF : hip_pkg::STATUS_FAIL;
		end
		return 1'b1;
	endfunction

	function automatic string prefix_text(input int k);
		case (k)
			1: return "$";
			2: return "x";
			3: return "X";
			4: return "\\u";
			5: return "#";
			6: return "#$";
			7: return "#x";
			8: return "#X";
			9: return "0x";
			10: return "0X";
			11: return "&#x";
			12: return "&#X";
			default: return "";
		endcase
	endfunction

	function automatic logic [7:0] white_char(input int k);
		case (k)
			0: return hip_pkg::CH_SPACE;
			1: return hip_pkg::CH_TAB;
			2: return hip_pkg::CH_CR;
			default: return hip_pkg::CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] rand_digit_char();
		int d;
		d = $urandom_range(0, 15);
		if (d < 10) return 8'(hip_pkg::CH_ZERO + d);
		if ($urandom_range(0, 1) == 1) return 8'(8'h41 + d - 10);
		return 8'(8'h61 + d - 10);
	endfunction

	function automatic logic [7:0] rand_nonhex();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (hex_nibble(c) != hip_pkg::HEX_NONE) c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
	endtask

	task automatic push_req(input logic [7:0] c, input bit first, input bit last,
			input bit drain, input bit burst);
		char_req_t r;
		r.ch = c;
		r.first = first;
		r.last = last;
		r.drain = drain;
		r.burst = burst;
		pending.push_back(r);
		n_total++;
	endtask

	task automatic send_line(input bit with_last, input bit drain, input bit burst);
		for (int i = 0; i < line.size(); i++)
			push_req(line[i], i == 0, with_last && i == line.size() - 1, drain && i == 0, burst);
		counted += line.size();
		line.delete();
	endtask

	task automatic send_text(input string s, input bit with_last);
		add_text(s);
		send_line(with_last, 1'b0, 1'b0);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.ch <= 8'h00;
			chars_if.first <= 1'b0;
			chars_if.last <= 1'b0;
			gap_left = 0;
		end else begin
			hold = chars_if.valid && !chars_if.ready;
			if (chars_if.valid && chars_if.ready) begin
				produced = parse_char(chars_if.ch, chars_if.first, chars_if.last, res);
				if (produced) expected.push_back(res);
				n_accepted++;
				if ($urandom_range(0, 59) == 0) in_calm = !in_calm;
			end
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
					chars_if.valid <= 1'b0;
				end else if (pending.size() != 0 &&
						!(pending[0].drain && expected.size() != 0)) begin
					req = pending.pop_front();
					chars_if.valid <= 1'b1;
					chars_if.ch <= req.ch;
					chars_if.first <= req.first;
					chars_if.last <= req.last;
					gap_left = (req.burst || in_calm) ? 0 : $urandom_range(0, 10);
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				if (expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status=%0d value=%h count=%0d", $time,
						results_if.status, results_if.value, results_if.read_count);
				end else begin
					want = expected.pop_front();
					n_results++;
					case (want.status)
						hip_pkg::STATUS_OK: n_ok++;
						hip_pkg::STATUS_OVF: n_ovf++;
						default: n_fail++;
					endcase
					if (results_if.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, results_if.status);
					end
					if (results_if.value !== want.value) begin
						errors++;
						$display("%0t: value expected %h actual %h", $time,
							want.value, results_if.value);
					end
					if (results_if.read_count !== want.read_count) begin
						errors++;
						$display("%0t: read_count expected %0d actual %0d", $time,
							want.read_count, results_if.read_count);
					end
				end
				if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
				stall_left = out_calm ? 0 : $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("tb_hex_integer_parser failed");
		$finish;
	end

	initial begin
		int kind;
		int nd;
		chars_if.valid = 1'b0;
		chars_if.ch = 8'h00;
		chars_if.first = 1'b0;
		chars_if.last = 1'b0;
		results_if.ready = 1'b0;
		p_phase = hip_pkg::PH_IDLE;
		p_acc = '0;
		p_used = 0;
		p_ndig = 0;

		// stray characters before any string
		push_req(8'h31, 1'b0, 1'b0, 1'b0, 1'b0);
		push_req(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);

		line.push_back(hip_pkg::CH_SPACE);
		line.push_back(hip_pkg::CH_TAB);
		line.push_back(hip_pkg::CH_CR);
		line.push_back(hip_pkg::CH_LF);
		add_text("$1F,");
		send_line(1'b1, 1'b0, 1'b0);
		send_text("x0", 1'b1);
		send_text("X7f", 1'b1);
		send_text("\\uABcd", 1'b1);
		send_text("#12", 1'b1);
		send_text("#$9", 1'b1);
		send_text("#xa", 1'b1);
		send_text("#X0", 1'b1);
		send_text("0x10", 1'b1);
		send_text("0X0", 1'b1);
		send_text("0", 1'b1);
		send_text("0;", 1'b1);
		send_text("&#x5F", 1'b1);
		send_text("&#X1", 1'b1);
		send_text("FFFFFFFFFFFFFFFF", 1'b1);
		send_text("0000fedcba9876543210", 1'b1);
		send_text("10000000000000000", 1'b1);
		send_text("\\q", 1'b1);
		send_text("&x1", 1'b1);
		send_text("&#y1", 1'b1);
		send_text("$g", 1'b1);
		send_text("g", 1'b1);
		send_text(" ", 1'b1);
		send_text("#", 1'b1);
		send_text("0x", 1'b1);
		send_text("&#", 1'b1);
		// terminator decides early; the rest is ignored
		send_text("5z99", 1'b1);
		// dropped by the next first mark
		send_text("12", 1'b0);
		line.push_back(8'h00);
		send_line(1'b1, 1'b1, 1'b0);
		line.push_back(8'hFF);
		send_line(1'b1, 1'b0, 1'b0);
		push_req(8'h41, 1'b0, 1'b1, 1'b0, 1'b0);

		counted = 0;
		while (counted < 560) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				repeat ($urandom_range(0, 3)) line.push_back(white_char($urandom_range(0, 3)));
				add_text(prefix_text($urandom_range(0, 12)));
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) line.push_back(hip_pkg::CH_ZERO);
				nd = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
				repeat (nd) line.push_back(rand_digit_char());
				if ($urandom_range(0, 1) == 1) begin
					line.push_back(rand_nonhex());
					repeat ($urandom_range(0, 2)) line.push_back(8'($urandom_range(0, 255)));
				end
				send_line($urandom_range(0, 14) != 0, $urandom_range(0, 39) == 0,
					$urandom_range(0, 9) == 0);
			end else if (kind < 85) begin
				repeat ($urandom_range(0, 1)) line.push_back(white_char($urandom_range(0, 3)));
				add_text(prefix_text($urandom_range(0, 12)).substr(0, $urandom_range(0, 1)));
				line.push_back(8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 3)) line.push_back(8'($urandom_range(0, 255)));
				send_line(1'b1, 1'b0, 1'b0);
			end else if (kind < 95) begin
				nd = $urandom_range(1, 6);
				for (int i = 0; i < nd; i++)
					push_req(8'($urandom_range(0, 255)), i == 0,
						$urandom_range(0, 2) == 0 || i == nd - 1, 1'b0, 1'b0);
				counted += nd;
			end else begin
				repeat ($urandom_range(1, 4))
					push_req(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1) == 1,
						1'b0, 1'b0);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total) @(posedge clk);
		while (expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (expected.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, expected.size());
		end

		$display("%0d characters sent incl. strays, restarts and bursts; %0d results checked",
			n_accepted, n_results);
		$display("outcomes: %0d ok, %0d no digit or bad prefix, %0d overflow, %0d mismatches",
			n_ok, n_fail, n_ovf, errors);
		if (errors == 0) begin
			$display("tb_hex_integer_parser passed");
		end else begin
			$display("tb_hex_integer_parser failed");
		end
		$finish;
	end

endmodule

FILE: hex_integer_parser.f
hdl/hip_pkg.sv
hdl/hip_in_if.sv
hdl/hip_out_if.sv
hdl/hip_step.sv
hdl/hex_integer_parser.sv
bench/tb_hex_integer_parser.sv
